/* rtl/core/pdcr_pkg.sv */
// ----------------------------------------------------------------------------
// pdcr_pkg: shared types and constants of the pointer camera rotation block
// Holds the register map, reset values, the CORDIC arctangent table and the
// word that carries sine and cosine from the CORDIC unit to the top level.
// ----------------------------------------------------------------------------
package pdcr_pkg;

    // Configuration port.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int TURN_W     = 12;
    localparam int START_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TURN_PER_PIXEL = 3'd0,
        REG_START_DIR_X    = 3'd1,
        REG_START_DIR_Y    = 3'd2,
        REG_START_PLANE_X  = 3'd3,
        REG_START_PLANE_Y  = 3'd4
    } t_cfg_reg;

    localparam logic [TURN_W-1:0]         RST_TURN_PER_PIXEL = 12'd16;
    localparam logic signed [START_W-1:0] RST_START_DIR_X    = -16'sd16384;
    localparam logic signed [START_W-1:0] RST_START_DIR_Y    = 16'sd0;
    localparam logic signed [START_W-1:0] RST_START_PLANE_X  = 16'sd0;
    localparam logic signed [START_W-1:0] RST_START_PLANE_Y  = 16'sd10813;

    // Angle and trig widths.
    localparam int ANGLE_W  = 16;
    localparam int RESID_W  = 14;
    localparam int TRIG_W   = 16;
    localparam int CORDIC_W = 34;
    localparam int ZW       = 33;
    localparam int ATAN_W   = 30;
    localparam int STEP_W   = 4;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0]   TRIG_ONE    = 16'sd16384;
    localparam logic signed [TRIG_W-1:0]   TRIG_M_ONE  = -16'sd16384;

    // Quadrant codes of the angle's top two bits.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_q14;
        logic signed [TRIG_W-1:0] sin_q14;
    } t_trig;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            4'd0:    v = 30'd536870912;
            4'd1:    v = 30'd316933406;
            4'd2:    v = 30'd167458907;
            4'd3:    v = 30'd85004756;
            4'd4:    v = 30'd42667331;
            4'd5:    v = 30'd21354465;
            4'd6:    v = 30'd10679838;
            4'd7:    v = 30'd5340245;
            4'd8:    v = 30'd2670163;
            4'd9:    v = 30'd1335087;
            4'd10:   v = 30'd667544;
            4'd11:   v = 30'd333772;
            4'd12:   v = 30'd166886;
            4'd13:   v = 30'd83443;
            4'd14:   v = 30'd41722;
            4'd15:   v = 30'd20861;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/pdcr_cordic.sv */
// ----------------------------------------------------------------------------
// pdcr_cordic: iterative sine and cosine of a 16-bit turn fraction
// One shared shift-add stage runs sixteen CORDIC steps, one per cycle, then
// the result is rounded to Q2.14 and moved to its quadrant.
// ----------------------------------------------------------------------------
module pdcr_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [pdcr_pkg::ANGLE_W-1:0]    i_angle,
    output pdcr_pkg::t_trig                 o_trig
);

    localparam int CW = pdcr_pkg::CORDIC_W;
    localparam int ZW = pdcr_pkg::ZW;
    localparam int TW = pdcr_pkg::TRIG_W;

    logic signed [CW-1:0]            r_x, r_y;
    logic signed [ZW-1:0]            r_z;
    logic [pdcr_pkg::STEP_W-1:0]     r_step;
    logic [1:0]                      r_quad;
    logic                            r_busy, r_round, r_done;
    logic signed [TW-1:0]            r_cos, r_sin;

    logic signed [CW-1:0]            dx, dy;
    logic signed [ZW-1:0]            atan_ext;
    logic signed [TW-1:0]            c_rnd, s_rnd;

    // Rounds a Q4.30 value to Q2.14 and clamps it to plus or minus one.
    function automatic logic signed [TW-1:0] round_q14(input logic signed [CW-1:0] v);
        logic signed [CW:0]   t;
        logic signed [CW-16:0] r;
        t = {v[CW-1], v} + (CW+1)'(32768);
        r = t[CW:16];
        if (r > (CW-15)'(signed'(pdcr_pkg::TRIG_ONE))) begin
            return pdcr_pkg::TRIG_ONE;
        end else if (r < (CW-15)'(signed'(pdcr_pkg::TRIG_M_ONE))) begin
            return pdcr_pkg::TRIG_M_ONE;
        end
        return r[TW-1:0];
    endfunction

    assign dx       = r_y >>> r_step;
    assign dy       = r_x >>> r_step;
    assign atan_ext = signed'(ZW'(pdcr_pkg::atan_turn(r_step)));
    assign c_rnd    = round_q14(r_x);
    assign s_rnd    = round_q14(r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            // The done pulse follows the rounding cycle.
            r_done <= r_round;
            if (i_start) begin
                r_x     <= pdcr_pkg::CORDIC_GAIN;
                r_y     <= '0;
                r_z     <= signed'({3'b000, i_angle[pdcr_pkg::RESID_W-1:0], 16'h0000});
                r_quad  <= i_angle[pdcr_pkg::ANGLE_W-1 -: 2];
                r_step  <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[ZW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_ext;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_ext;
                end
                r_step <= r_step + 1'b1;
                if (r_step == '1) begin
                    r_busy  <= 1'b0;
                    r_round <= 1'b1;
                end
            end else if (r_round) begin
                r_round <= 1'b0;
                case (r_quad)
                    pdcr_pkg::QUAD_0: begin r_cos <= c_rnd;  r_sin <= s_rnd;  end
                    pdcr_pkg::QUAD_1: begin r_cos <= -s_rnd; r_sin <= c_rnd;  end
                    pdcr_pkg::QUAD_2: begin r_cos <= -c_rnd; r_sin <= -s_rnd; end
                    default:          begin r_cos <= s_rnd;  r_sin <= -c_rnd; end
                endcase
            end
        end
    end

    assign o_trig.done    = r_done;
    assign o_trig.cos_q14 = r_cos;
    assign o_trig.sin_q14 = r_sin;

endmodule

/* rtl/core/pointer_delta_camera_rotation.sv */
// ----------------------------------------------------------------------------
// pointer_delta_camera_rotation: camera turn driven by horizontal pointer motion
// Rotates the view direction and camera plane vectors together by an angle
// proportional to the change in horizontal pointer position.
// ----------------------------------------------------------------------------
// Each input word carries a pointer position and a restart flag, and each one
// yields exactly one output word with the four vectors and a rotated flag. A
// restart loads the start vectors and disarms tracking; the next normal word
// only records the position. After that, a change of more than one pixel turns
// both vectors by change times turn_per_pixel (a 16-bit turn fraction that
// wraps). The angle product is formed in the cycle that accepts the word. A
// word that does not rotate goes straight to the finish state. A rotating word
// first loads the shared CORDIC shift-add unit, which runs its sixteen steps,
// rounds sine and cosine and hands them over; then a single multiplier and
// accumulator form the four rotated coordinates one product at a time, each
// product multiplied and then accumulated, and the vectors are committed. In
// the finish state the word moves into the output register once that register
// is free. The input is not ready while a word is in work or while reset is
// held, so a new word is taken only after the last one has moved into the
// output register, which includes any time in which a finished word waits
// for the output register to free up. A finished output word waits in its
// own register, so the next input word can be accepted meanwhile.
// Configuration writes are taken at any time but must only be issued while
// the block is idle; the start vectors take effect at the next restart.
module pointer_delta_camera_rotation #(
    parameter int POSITION_BITS = 12,
    parameter int VECTOR_BITS   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [pdcr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pdcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [POSITION_BITS-1:0]           i_pointer_x,
    input  logic                               i_restart,
    // Output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [VECTOR_BITS-1:0]      o_out_dir_x,
    output logic signed [VECTOR_BITS-1:0]      o_out_dir_y,
    output logic signed [VECTOR_BITS-1:0]      o_out_plane_x,
    output logic signed [VECTOR_BITS-1:0]      o_out_plane_y,
    output logic                               o_rotated
);

    localparam int DELTA_W = POSITION_BITS + 1;
    localparam int AMUL_W  = DELTA_W + pdcr_pkg::TURN_W + 1;
    localparam int TW      = pdcr_pkg::TRIG_W;
    localparam int PROD_W  = VECTOR_BITS + TW;
    localparam int ACC_W   = PROD_W + 1;
    localparam int SH_W    = ACC_W + 1 - 14;
    localparam int EXT_W   = 33;
    localparam longint VMAX = (64'sd1 <<< (VECTOR_BITS - 1)) - 64'sd1;
    localparam longint VMIN = -(64'sd1 <<< (VECTOR_BITS - 1));

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TRIG   = 6'b000010,
        S_MUL    = 6'b000100,
        S_ACC    = 6'b001000,
        S_COMMIT = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    // Saturates a 16-bit start value to the vector width.
    function automatic logic signed [VECTOR_BITS-1:0] sat_start(
        input logic signed [pdcr_pkg::START_W-1:0] v);
        logic signed [EXT_W-1:0] w;
        w = EXT_W'(v);
        if (w > signed'(EXT_W'(VMAX))) begin
            return VECTOR_BITS'(VMAX);
        end else if (w < signed'(EXT_W'(VMIN))) begin
            return VECTOR_BITS'(VMIN);
        end
        return w[VECTOR_BITS-1:0];
    endfunction

    // Saturates a rotated coordinate to the vector width.
    function automatic logic signed [VECTOR_BITS-1:0] sat_rot(input logic signed [SH_W-1:0] v);
        if (v > signed'(SH_W'(VMAX))) begin
            return VECTOR_BITS'(VMAX);
        end else if (v < signed'(SH_W'(VMIN))) begin
            return VECTOR_BITS'(VMIN);
        end
        return v[VECTOR_BITS-1:0];
    endfunction

    // Control state.
    t_state                              r_state;
    logic                                r_armed;
    logic [POSITION_BITS-1:0]            r_last_x;
    logic                                r_trig_start;
    logic                                r_rot;
    logic                                r_out_valid;
    logic [1:0]                          r_k;
    logic                                r_t;

    // Configuration registers.
    logic [pdcr_pkg::TURN_W-1:0]         r_turn;
    logic signed [pdcr_pkg::START_W-1:0] r_st_dir_x, r_st_dir_y, r_st_plane_x, r_st_plane_y;

    // Vector state and datapath registers.
    logic signed [VECTOR_BITS-1:0]       r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic signed [VECTOR_BITS-1:0]       r_new [4];
    logic [pdcr_pkg::ANGLE_W-1:0]        r_angle;
    logic signed [PROD_W-1:0]            r_prod;
    logic signed [ACC_W-1:0]             r_acc;

    // Output registers.
    logic signed [VECTOR_BITS-1:0]       r_o_dir_x, r_o_dir_y, r_o_plane_x, r_o_plane_y;
    logic                                r_o_rot;

    pdcr_pkg::t_trig                     trig;

    logic                                in_acc, out_free;
    logic signed [DELTA_W-1:0]           delta;
    logic                                big_move;
    logic signed [AMUL_W-1:0]            angle_prod;
    logic signed [VECTOR_BITS-1:0]       pair_x, pair_y, op_vec;
    logic signed [TW-1:0]                op_trig;
    logic signed [PROD_W-1:0]            prod_c;
    logic signed [ACC_W-1:0]             acc_base, prod_ext, acc_sum;
    logic signed [ACC_W:0]               acc_rnd;
    logic signed [SH_W-1:0]              acc_sh;

    pdcr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_trig_start),
        .i_angle (r_angle),
        .o_trig  (trig)
    );

    // No word is taken while reset is held.
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Signed pointer change and the wrapped rotation angle.
    assign delta      = signed'({1'b0, i_pointer_x}) - signed'({1'b0, r_last_x});
    assign big_move   = (delta > DELTA_W'(1)) || (delta < -(DELTA_W'(1)));
    assign angle_prod = AMUL_W'(delta) * signed'(AMUL_W'({1'b0, r_turn}));

    // Operand selection for the shared multiplier. Coordinate k picks the
    // vector pair and the x or y output; term t picks the first or second
    // product. Only the x outputs subtract their second product.
    assign pair_x   = r_k[1] ? r_plane_x : r_dir_x;
    assign pair_y   = r_k[1] ? r_plane_y : r_dir_y;
    assign op_vec   = r_t ? pair_y : pair_x;
    assign op_trig  = (r_k[0] ^ r_t) ? trig.sin_q14 : trig.cos_q14;
    assign prod_c   = PROD_W'(op_vec) * PROD_W'(op_trig);

    assign acc_base = r_t ? r_acc : '0;
    assign prod_ext = ACC_W'(r_prod);
    assign acc_sum  = (!r_k[0] && r_t) ? (acc_base - prod_ext) : (acc_base + prod_ext);
    assign acc_rnd  = (ACC_W+1)'(acc_sum) + (ACC_W+1)'(8192);
    assign acc_sh   = acc_rnd[ACC_W:14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= 1'b0;
            r_last_x     <= '0;
            r_trig_start <= 1'b0;
            r_rot        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_k          <= '0;
            r_t          <= 1'b0;
            r_turn       <= pdcr_pkg::RST_TURN_PER_PIXEL;
            r_st_dir_x   <= pdcr_pkg::RST_START_DIR_X;
            r_st_dir_y   <= pdcr_pkg::RST_START_DIR_Y;
            r_st_plane_x <= pdcr_pkg::RST_START_PLANE_X;
            r_st_plane_y <= pdcr_pkg::RST_START_PLANE_Y;
            r_dir_x      <= sat_start(pdcr_pkg::RST_START_DIR_X);
            r_dir_y      <= sat_start(pdcr_pkg::RST_START_DIR_Y);
            r_plane_x    <= sat_start(pdcr_pkg::RST_START_PLANE_X);
            r_plane_y    <= sat_start(pdcr_pkg::RST_START_PLANE_Y);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pdcr_pkg::REG_TURN_PER_PIXEL: r_turn <= i_cfg_data[pdcr_pkg::TURN_W-1:0];
                    pdcr_pkg::REG_START_DIR_X:    r_st_dir_x   <= signed'(i_cfg_data);
                    pdcr_pkg::REG_START_DIR_Y:    r_st_dir_y   <= signed'(i_cfg_data);
                    pdcr_pkg::REG_START_PLANE_X:  r_st_plane_x <= signed'(i_cfg_data);
                    pdcr_pkg::REG_START_PLANE_Y:  r_st_plane_y <= signed'(i_cfg_data);
                    default: ;
                endcase
            end

            // In S_FIN a leaving word is replaced by the next one below.
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rot <= 1'b0;
                        if (i_restart) begin
                            r_dir_x   <= sat_start(r_st_dir_x);
                            r_dir_y   <= sat_start(r_st_dir_y);
                            r_plane_x <= sat_start(r_st_plane_x);
                            r_plane_y <= sat_start(r_st_plane_y);
                            r_armed   <= 1'b0;
                            r_state   <= S_FIN;
                        end else begin
                            r_last_x <= i_pointer_x;
                            r_armed  <= 1'b1;
                            if (r_armed && big_move) begin
                                r_angle      <= angle_prod[pdcr_pkg::ANGLE_W-1:0];
                                r_trig_start <= 1'b1;
                                r_state      <= S_TRIG;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_TRIG: begin
                    r_trig_start <= 1'b0;
                    if (trig.done) begin
                        r_k     <= '0;
                        r_t     <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= prod_c;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_t) begin
                        r_acc   <= acc_sum;
                        r_t     <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_new[r_k] <= sat_rot(acc_sh);
                        r_t        <= 1'b0;
                        r_k        <= r_k + 1'b1;
                        r_state    <= (r_k == 2'd3) ? S_COMMIT : S_MUL;
                    end
                end
                S_COMMIT: begin
                    // Both coordinates of a pair came from the old values,
                    // so the vectors are updated only now.
                    r_dir_x   <= r_new[0];
                    r_dir_y   <= r_new[1];
                    r_plane_x <= r_new[2];
                    r_plane_y <= r_new[3];
                    r_rot     <= 1'b1;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output word register, loaded when a finished word leaves S_FIN.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_o_dir_x   <= r_dir_x;
            r_o_dir_y   <= r_dir_y;
            r_o_plane_x <= r_plane_x;
            r_o_plane_y <= r_plane_y;
            r_o_rot     <= r_rot;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_dir_x   = r_o_dir_x;
    assign o_out_dir_y   = r_o_dir_y;
    assign o_out_plane_x = r_o_plane_x;
    assign o_out_plane_y = r_o_plane_y;
    assign o_rotated     = r_o_rot;

endmodule
